@@ rtl/tea_pkg.sv @@
// shared constants and round helpers for the tea block cipher
`default_nettype none

package tea_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned BLOCK_W = 2 * WORD_W;
   localparam int unsigned DEFAULT_ROUNDS = 32;
   localparam int unsigned KEY_WORDS = 4;
   localparam int unsigned CSR_ADDR_W = $clog2(KEY_WORDS);

   localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

   // opcodes carried in tuser
   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   // register indexes of the csr port
   localparam logic [CSR_ADDR_W-1:0] CSR_KEY_ZERO  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_KEY_ONE   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_KEY_TWO   = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_KEY_THREE = 2'd3;

   typedef logic [WORD_W-1:0] word_type;

   // delta times n, wrapped to one word; only evaluated at elaboration
   function automatic word_type delta_times(input int unsigned n);
      logic [2*WORD_W-1:0] prod;
      prod = {{WORD_W{1'b0}}, TEA_DELTA} * (2*WORD_W)'(n);
      return prod[WORD_W-1:0];
   endfunction

   // feistel mixing term of one half-round
   function automatic word_type mix(input word_type w, input word_type sum,
                                    input word_type ka, input word_type kb);
      return ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
   endfunction

endpackage

`default_nettype wire

@@ rtl/tea_block_cipher.sv @@
// tea block cipher: one half-round per pipeline stage with an output skid pair
//
// Input words arrive on req_: tdata holds the 64-bit block, tuser the opcode
// (encrypt or decrypt). Results leave on rsp_ with the transformed block in
// tdata. The user writes the 128-bit key through csr_we / csr_addr / csr_wdata,
// one 32-bit key word per write, only while no word is in flight; the user's duty.
//
// Every half-round of the cipher has its own register stage, 2*ROUNDS stages
// after an input register, so while neither side stalls a new word can enter in
// every cycle and one word leaves per cycle. An accepted word passes the input
// register, the half-round stages and the output register on its way to rsp_tvalid.
//
// Reset clears all stage valid bits, both output valid bits and the key to zero.
// When the receiver holds rsp_tready low the pipeline keeps running until the
// second output slot fills; then req_tready drops and all stages hold.
// Nothing is lost or repeated across a stall.
`default_nettype none

module tea_block_cipher #(
   parameter int unsigned ROUNDS = tea_pkg::DEFAULT_ROUNDS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request words
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [tea_pkg::BLOCK_W-1:0]     req_tdata,  // second_half (upper), first_half (lower)
   input  wire logic                            req_tuser,  // opcode
   // result words
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   output      logic [tea_pkg::BLOCK_W-1:0]     rsp_tdata,  // out_second_half (upper), out_first_half (lower)
   // key registers
   input  wire logic                            csr_we,
   input  wire logic [tea_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [tea_pkg::WORD_W-1:0]      csr_wdata
);

   localparam int unsigned STAGES = 2 * ROUNDS;

   tea_pkg::word_type key_ff [tea_pkg::KEY_WORDS];

   // stage 0 is the input register, stage s+1 holds the result of half-round s
   logic              v_ff  [STAGES+1];
   logic              op_ff [STAGES+1];
   tea_pkg::word_type x_ff  [STAGES+1];
   tea_pkg::word_type y_ff  [STAGES+1];

   logic              en;

   logic              out_v_ff, out_v_in;
   logic              skid_v_ff, skid_v_in;
   logic [tea_pkg::BLOCK_W-1:0] out_d_ff, out_d_in;
   logic [tea_pkg::BLOCK_W-1:0] skid_d_ff, skid_d_in;
   logic              push, pop;
   logic [tea_pkg::BLOCK_W-1:0] push_d;

   // key register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tea_pkg::KEY_WORDS; i++) key_ff[i] <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            tea_pkg::CSR_KEY_ZERO:  key_ff[0] <= csr_wdata;
            tea_pkg::CSR_KEY_ONE:   key_ff[1] <= csr_wdata;
            tea_pkg::CSR_KEY_TWO:   key_ff[2] <= csr_wdata;
            tea_pkg::CSR_KEY_THREE: key_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // whole pipeline moves while the second output slot is free
   assign en = !skid_v_ff;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op_ff[0] <= req_tuser;
         x_ff[0]  <= req_tdata[tea_pkg::WORD_W-1:0];
         y_ff[0]  <= req_tdata[tea_pkg::BLOCK_W-1:tea_pkg::WORD_W];
      end
   end

   for (genvar s = 0; s < STAGES; s++) begin : g_half
      localparam int unsigned RND = s / 2;
      localparam bit SECOND = (s % 2) == 1;
      localparam tea_pkg::word_type ENC_SUM = tea_pkg::delta_times(RND + 1);
      localparam tea_pkg::word_type DEC_SUM = tea_pkg::delta_times(ROUNDS - RND);

      logic              dec;
      logic              upd_x;
      tea_pkg::word_type m_src;
      tea_pkg::word_type m_sum;
      tea_pkg::word_type m_ka;
      tea_pkg::word_type m_kb;
      tea_pkg::word_type m_val;
      tea_pkg::word_type tgt;
      tea_pkg::word_type res;
      tea_pkg::word_type x_in;
      tea_pkg::word_type y_in;

      always_comb begin
         dec = (op_ff[s] == tea_pkg::OP_DECRYPT);
         // encrypt updates x first then y, decrypt the reverse
         upd_x = SECOND ? dec : !dec;
         m_src = upd_x ? y_ff[s] : x_ff[s];
         m_sum = dec ? DEC_SUM : ENC_SUM;
         m_ka  = upd_x ? key_ff[0] : key_ff[2];
         m_kb  = upd_x ? key_ff[1] : key_ff[3];
         m_val = tea_pkg::mix(m_src, m_sum, m_ka, m_kb);
         tgt   = upd_x ? x_ff[s] : y_ff[s];
         res   = dec ? (tgt - m_val) : (tgt + m_val);
         x_in  = upd_x ? res : x_ff[s];
         y_in  = upd_x ? y_ff[s] : res;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else if (en) begin
            v_ff[s+1] <= v_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            op_ff[s+1] <= op_ff[s];
            x_ff[s+1]  <= x_in;
            y_ff[s+1]  <= y_in;
         end
      end
   end

   // output register plus skid slot
   assign push   = en && v_ff[STAGES];
   assign push_d = {y_ff[STAGES], x_ff[STAGES]};
   assign pop    = out_v_ff && rsp_tready;

   always_comb begin
      out_v_in  = out_v_ff;
      out_d_in  = out_d_ff;
      skid_v_in = skid_v_ff;
      skid_d_in = skid_d_ff;
      if (pop || !out_v_ff) begin
         if (skid_v_ff) begin
            out_v_in  = 1'b1;
            out_d_in  = skid_d_ff;
            skid_v_in = push;
            skid_d_in = push_d;
         end else begin
            out_v_in = push;
            out_d_in = push_d;
         end
      end else if (push) begin
         skid_v_in = 1'b1;
         skid_d_in = push_d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_d_ff  <= out_d_in;
      skid_d_ff <= skid_d_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;

endmodule

`default_nettype wire

@@ dv/tea_block_cipher_tb.sv @@
// self-checking testbench for the tea block cipher: streamed blocks checked against a tb predictor
`timescale 1ns / 1ps

module tea_block_cipher_tb;

   localparam int unsigned NUM_ROUNDS = tea_pkg::DEFAULT_ROUNDS;
   localparam int unsigned PIPE_LATENCY = 2 * NUM_ROUNDS + 1;
   localparam int unsigned RANDOM_PER_KEY = 316;

   typedef struct {
      logic              op;
      tea_pkg::word_type first;
      tea_pkg::word_type second;
   } block_req_type;

   typedef struct packed {
      tea_pkg::word_type second;
      tea_pkg::word_type first;
   } block_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [tea_pkg::BLOCK_W-1:0]    req_tdata = '0;   // second_half (upper), first_half (lower)
   logic                           req_tuser = tea_pkg::OP_ENCRYPT;  // opcode
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [tea_pkg::BLOCK_W-1:0]    rsp_tdata;   // out_second_half (upper), out_first_half (lower)
   logic                           csr_we = 1'b0;
   logic [tea_pkg::CSR_ADDR_W-1:0] csr_addr = tea_pkg::CSR_KEY_ZERO;
   logic [tea_pkg::WORD_W-1:0]     csr_wdata = '0;

   tea_pkg::word_type key_copy [tea_pkg::KEY_WORDS];
   block_req_type     pending_blocks [$];
   block_type         expected_blocks [$];

   int unsigned blocks_sent = 0;
   int unsigned encrypts_sent = 0;
   int unsigned decrypts_sent = 0;
   int unsigned blocks_checked = 0;
   int unsigned mismatch_count = 0;
   int unsigned key_settings = 1;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;

   tea_block_cipher dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic tea_pkg::word_type feistel_term(input tea_pkg::word_type w,
                                                      input tea_pkg::word_type sum,
                                                      input tea_pkg::word_type ka,
                                                      input tea_pkg::word_type kb);
      return ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
   endfunction

   function automatic block_type tea_transform(input block_req_type req);
      tea_pkg::word_type x;
      tea_pkg::word_type y;
      tea_pkg::word_type sum;
      block_type         res;
      x = req.first;
      y = req.second;
      sum = '0;
      if (req.op == tea_pkg::OP_ENCRYPT) begin
         for (int r = 0; r < NUM_ROUNDS; r++) begin
            sum += tea_pkg::TEA_DELTA;
            x += feistel_term(y, sum, key_copy[tea_pkg::CSR_KEY_ZERO],
                              key_copy[tea_pkg::CSR_KEY_ONE]);
            y += feistel_term(x, sum, key_copy[tea_pkg::CSR_KEY_TWO],
                              key_copy[tea_pkg::CSR_KEY_THREE]);
         end
      end else begin
         // start from delta times the round count, wrapped to one word
         repeat (NUM_ROUNDS) sum += tea_pkg::TEA_DELTA;
         for (int r = 0; r < NUM_ROUNDS; r++) begin
            y -= feistel_term(x, sum, key_copy[tea_pkg::CSR_KEY_TWO],
                              key_copy[tea_pkg::CSR_KEY_THREE]);
            x -= feistel_term(y, sum, key_copy[tea_pkg::CSR_KEY_ZERO],
                              key_copy[tea_pkg::CSR_KEY_ONE]);
            sum -= tea_pkg::TEA_DELTA;
         end
      end
      res.first = x;
      res.second = y;
      return res;
   endfunction

   function automatic tea_pkg::word_type pick_word();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return tea_pkg::word_type'(1) << $urandom_range(tea_pkg::WORD_W - 1);
         default: return $urandom;
      endcase
   endfunction

   // driver: valid holds until the word is taken, new words may idle at random
   always @(posedge clock) begin
      logic taken;
      logic steady;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         taken = req_tvalid && req_tready;
         if (taken) begin
            expected_blocks.push_back(tea_transform(pending_blocks[0]));
            if (pending_blocks[0].op == tea_pkg::OP_ENCRYPT) encrypts_sent++;
            else decrypts_sent++;
            pending_blocks.pop_front();
            blocks_sent++;
         end
         if (!req_tvalid || taken) begin
            steady = blocks_sent >= 900 && blocks_sent < 1200;
            if (pending_blocks.size() > 0 && (steady || $urandom_range(99) >= 32)) begin
               req_tvalid <= 1'b1;
               req_tdata <= {pending_blocks[0].second, pending_blocks[0].first};
               req_tuser <= pending_blocks[0].op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each result word against the oldest predicted block
   always @(posedge clock) begin
      block_type want;
      block_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_blocks.size() == 0) begin
               $error("unexpected result word: first %h second %h", got.first, got.second);
               mismatch_count++;
            end else begin
               want = expected_blocks.pop_front();
               if (got.first !== want.first) begin
                  $error("out_first_half: expected %h, actual %h", want.first, got.first);
                  mismatch_count++;
               end
               if (got.second !== want.second) begin
                  $error("out_second_half: expected %h, actual %h", want.second, got.second);
                  mismatch_count++;
               end
            end
            blocks_checked++;
         end
         // one long hold-off so the pipeline fills and backs up into req_tready
         if (!hold_done && blocks_checked >= 500) begin
            hold_done = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (blocks_checked >= 900 && blocks_checked < 1200) ||
                          ($urandom_range(99) >= 32);
         end
      end
   end

   task automatic wait_drained();
      while (pending_blocks.size() != 0 || expected_blocks.size() != 0 || req_tvalid)
         @(negedge clock);
   endtask

   task automatic write_csr(input logic [tea_pkg::CSR_ADDR_W-1:0] idx,
                            input tea_pkg::word_type value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      key_copy[idx] = value;
   endtask

   task automatic load_key(input tea_pkg::word_type k0, input tea_pkg::word_type k1,
                           input tea_pkg::word_type k2, input tea_pkg::word_type k3);
      wait_drained();
      write_csr(tea_pkg::CSR_KEY_ZERO, k0);
      write_csr(tea_pkg::CSR_KEY_ONE, k1);
      write_csr(tea_pkg::CSR_KEY_TWO, k2);
      write_csr(tea_pkg::CSR_KEY_THREE, k3);
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      key_settings++;
   endtask

   task automatic queue_block(input logic op, input tea_pkg::word_type a,
                              input tea_pkg::word_type b);
      block_req_type req;
      req.op = op;
      req.first = a;
      req.second = b;
      pending_blocks.push_back(req);
   endtask

   // random blocks; a quarter of the draws become encrypt-then-decrypt round trip pairs
   task automatic queue_random(input int unsigned count);
      int unsigned   queued;
      block_req_type req;
      block_type     cipher;
      queued = 0;
      while (queued < count) begin
         req.op = 1'($urandom_range(1));
         req.first = pick_word();
         req.second = pick_word();
         if ($urandom_range(3) == 0) begin
            req.op = tea_pkg::OP_ENCRYPT;
            cipher = tea_transform(req);
            pending_blocks.push_back(req);
            queue_block(tea_pkg::OP_DECRYPT, cipher.first, cipher.second);
            queued += 2;
         end else begin
            pending_blocks.push_back(req);
            queued++;
         end
      end
   endtask

   initial begin
      for (int i = 0; i < tea_pkg::KEY_WORDS; i++) key_copy[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // key never written: all-zero key from reset
      for (int op = 0; op < 2; op++) begin
         queue_block(op[0], '0, '0);
         queue_block(op[0], '1, '1);
         queue_block(op[0], '0, '1);
         queue_block(op[0], '1, '0);
         queue_block(op[0], 32'h8000_0000, 32'h0000_0001);
      end
      queue_random(RANDOM_PER_KEY);

      load_key('1, '1, '1, '1);
      queue_block(tea_pkg::OP_ENCRYPT, '0, '0);
      queue_block(tea_pkg::OP_DECRYPT, '0, '0);
      queue_block(tea_pkg::OP_ENCRYPT, '1, '1);
      queue_block(tea_pkg::OP_DECRYPT, '1, '1);
      queue_block(tea_pkg::OP_ENCRYPT, 32'h1234_5678, 32'h9ABC_DEF0);
      queue_block(tea_pkg::OP_DECRYPT, 32'h1234_5678, 32'h9ABC_DEF0);
      queue_random(RANDOM_PER_KEY);

      load_key('0, '1, '0, '1);
      queue_random(RANDOM_PER_KEY);

      for (int k = 0; k < 3; k++) begin
         load_key($urandom, $urandom, $urandom, $urandom);
         queue_random(RANDOM_PER_KEY);
      end

      wait_drained();
      repeat (PIPE_LATENCY + 10) @(posedge clock);
      $display("%0d blocks (%0d encrypt, %0d decrypt) under %0d key settings, %0d results",
               blocks_sent, encrypts_sent, decrypts_sent, key_settings, blocks_checked);
      $display("stimulus covered edge words, round trips, a long output stall and idle gaps");
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule

@@ tea_block_cipher.f @@
rtl/tea_pkg.sv
rtl/tea_block_cipher.sv
dv/tea_block_cipher_tb.sv
